[hw/rtl/cha_pkg.sv]
// ----------------------------------------------------------------------------
// cha_pkg
// Shared types, constants and the arctangent table for the heading block.
// ----------------------------------------------------------------------------
package cha_pkg;

	localparam int unsigned ANGLE_ITERATIONS_DEF = 16;
	localparam int unsigned CNT_W = 5;
	localparam int unsigned DIV_STEPS = 18;
	localparam int unsigned Z_W = 25;
	localparam int unsigned V_W = 20;

	localparam logic signed [Z_W-1:0] Z_P45  = Z_W'(45 * 65536);
	localparam logic signed [Z_W-1:0] Z_P90  = Z_W'(90 * 65536);
	localparam logic signed [Z_W-1:0] Z_P135 = Z_W'(135 * 65536);
	localparam logic signed [Z_W-1:0] Z_P180 = Z_W'(180 * 65536);

	typedef struct packed {
		logic load;
		logic clear;
		logic div_init;
		logic div_step;
		logic div_store;
		logic axis;
		logic cordic_init;
		logic cordic_step;
		logic [CNT_W-1:0] iter;
	} cmd_t;

	typedef struct packed {
		logic exact;
	} status_t;

	function automatic logic [21:0] atan_entry(input logic [CNT_W-1:0] idx);
		logic [21:0] v;
		unique case (idx)
			5'd0: v = 22'd2949120;
			5'd1: v = 22'd1740967;
			5'd2: v = 22'd919879;
			5'd3: v = 22'd466945;
			5'd4: v = 22'd234379;
			5'd5: v = 22'd117304;
			5'd6: v = 22'd58666;
			5'd7: v = 22'd29335;
			5'd8: v = 22'd14668;
			5'd9: v = 22'd7334;
			5'd10: v = 22'd3667;
			5'd11: v = 22'd1833;
			5'd12: v = 22'd917;
			5'd13: v = 22'd458;
			5'd14: v = 22'd229;
			5'd15: v = 22'd115;
			5'd16: v = 22'd57;
			5'd17: v = 22'd29;
			5'd18: v = 22'd14;
			5'd19: v = 22'd7;
			5'd20: v = 22'd4;
			5'd21: v = 22'd2;
			5'd22: v = 22'd1;
			default: v = 22'd0;
		endcase
		return v;
	endfunction

endpackage

[hw/rtl/compass_heading_autocal.sv]
// ----------------------------------------------------------------------------
// compass_heading_autocal
// Self-calibrating compass heading from raw X and Y magnetometer samples.
// ----------------------------------------------------------------------------
// A sample runs two 18-step divisions on one shared restoring divider, then
// the CORDIC iterations unless the angle is an exact case. One item is worked
// on at a time; a result held at the output does not block the next item, but
// a finished result waits for a free output register. Reset zeroes the
// calibration bounds and empties the output.
module compass_heading_autocal #(
	parameter int unsigned ANGLE_ITERATIONS = cha_pkg::ANGLE_ITERATIONS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [31:0] s_axis_tdata,  // sample_x [15:0], sample_y [31:16]
	input  logic        s_axis_tuser,  // opcode
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [15:0] m_axis_tdata   // heading_deg [8:0], zeros above
);

	cha_pkg::cmd_t cmd;
	cha_pkg::status_t status;
	logic out_load;
	logic [8:0] heading;
	logic [8:0] out_q;
	logic out_valid_q;

	cha_ctrl #(.ANGLE_ITERATIONS(ANGLE_ITERATIONS)) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_clear (s_axis_tuser),
		.in_ready (s_axis_tready),
		.out_free (!out_valid_q || m_axis_tready),
		.out_load (out_load),
		.status   (status),
		.cmd      (cmd)
	);

	cha_dp u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.sample_x    (s_axis_tdata[15:0]),
		.sample_y    (s_axis_tdata[31:16]),
		.status      (status),
		.heading_deg (heading)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) out_q <= heading;
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata = {7'd0, out_q};

endmodule

[hw/rtl/cha_dp.sv]
// ----------------------------------------------------------------------------
// cha_dp
// Datapath: calibration bounds, shared restoring divider and CORDIC unit.
// ----------------------------------------------------------------------------
module cha_dp (
	input  logic                 clk,
	input  logic                 arst_n,
	input  cha_pkg::cmd_t        cmd,
	input  logic signed [15:0]   sample_x,
	input  logic signed [15:0]   sample_y,
	output cha_pkg::status_t     status,
	output logic [8:0]           heading_deg
);

	logic signed [15:0] xmin_q, xmax_q, ymin_q, ymax_q;
	logic signed [15:0] smp_x_q, smp_y_q;
	logic [17:0] rem_q, bits_q, quo_q;
	logic [16:0] rng_q;
	logic neg_q;
	logic signed [18:0] sx_q, sy_q;
	logic signed [cha_pkg::V_W-1:0] x_q, y_q;
	logic signed [cha_pkg::Z_W-1:0] z_q;

	logic signed [15:0] xlo, xhi, ylo, yhi;
	logic signed [15:0] a_s, a_lo, a_hi;
	logic signed [16:0] sum, mid, rng;
	logic signed [17:0] dif;
	logic [17:0] mag;
	logic [18:0] trial;
	logic ge;
	logic signed [18:0] qval;
	logic [18:0] ax, ay;
	logic signed [cha_pkg::V_W-1:0] xs, ys;
	logic signed [cha_pkg::Z_W-1:0] tab;
	logic signed [9:0] hd;

	always_comb begin
		xlo = (xmin_q == 16'sd0 && xmax_q == 16'sd0) ? sample_x : xmin_q;
		xhi = (xmin_q == 16'sd0 && xmax_q == 16'sd0) ? sample_x : xmax_q;
		ylo = (ymin_q == 16'sd0 && ymax_q == 16'sd0) ? sample_y : ymin_q;
		yhi = (ymin_q == 16'sd0 && ymax_q == 16'sd0) ? sample_y : ymax_q;
		if (sample_x < xlo) xlo = sample_x;
		if (sample_x > xhi) xhi = sample_x;
		if (sample_y < ylo) ylo = sample_y;
		if (sample_y > yhi) yhi = sample_y;
	end

	always_comb begin
		a_s  = cmd.axis ? smp_y_q : smp_x_q;
		a_lo = cmd.axis ? ymin_q : xmin_q;
		a_hi = cmd.axis ? ymax_q : xmax_q;
		sum  = 17'(a_lo) + 17'(a_hi);
		mid  = (sum + $signed({16'd0, sum[16]})) >>> 1;
		dif  = 18'(a_s) - 18'(mid);
		mag  = dif[17] ? 18'(-dif) : 18'(dif);
		rng  = 17'(a_hi) - 17'(a_lo);
		trial = {rem_q, bits_q[17]};
		ge    = trial >= {2'b00, rng_q};
		qval  = (rng_q == 17'd0) ? 19'sd0 :
			(neg_q ? -$signed({1'b0, quo_q}) : $signed({1'b0, quo_q}));
	end

	always_comb begin
		ax = sx_q[18] ? 19'(-sx_q) : 19'(sx_q);
		ay = sy_q[18] ? 19'(-sy_q) : 19'(sy_q);
		status.exact = (sy_q == 19'sd0) || (sx_q == 19'sd0) || (ax == ay);
		xs  = x_q >>> cmd.iter;
		ys  = y_q >>> cmd.iter;
		tab = cha_pkg::Z_W'(cha_pkg::atan_entry(cmd.iter));
		hd  = 10'(z_q >>> 16);
		if (z_q[cha_pkg::Z_W-1] && z_q[15:0] != 16'd0) hd = hd + 10'sd1;
		if (hd <= 10'sd0) hd = hd + 10'sd360;
		heading_deg = hd[8:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			xmin_q <= '0;
			xmax_q <= '0;
			ymin_q <= '0;
			ymax_q <= '0;
		end else if (cmd.load) begin
			if (cmd.clear) begin
				xmin_q <= '0;
				xmax_q <= '0;
				ymin_q <= '0;
				ymax_q <= '0;
			end else begin
				xmin_q <= xlo;
				xmax_q <= xhi;
				ymin_q <= ylo;
				ymax_q <= yhi;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			smp_x_q <= sample_x;
			smp_y_q <= sample_y;
		end
		if (cmd.div_init) begin
			rem_q  <= mag >> 2;
			bits_q <= {mag[1:0], 16'd0};
			neg_q  <= dif[17];
			rng_q  <= 17'(rng);
			quo_q  <= '0;
		end else if (cmd.div_step) begin
			rem_q  <= ge ? 18'(trial - {2'b00, rng_q}) : trial[17:0];
			bits_q <= {bits_q[16:0], 1'b0};
			quo_q  <= {quo_q[16:0], ge};
		end
		if (cmd.div_store) begin
			if (cmd.axis) sy_q <= qval;
			else sx_q <= qval;
		end
		if (cmd.cordic_init) begin
			if (status.exact || !sx_q[18]) begin
				x_q <= cha_pkg::V_W'(sx_q);
				y_q <= cha_pkg::V_W'(sy_q);
			end else if (!sy_q[18]) begin
				x_q <= cha_pkg::V_W'(sy_q);
				y_q <= -cha_pkg::V_W'(sx_q);
			end else begin
				x_q <= -cha_pkg::V_W'(sy_q);
				y_q <= cha_pkg::V_W'(sx_q);
			end
			if (sy_q == 19'sd0) begin
				z_q <= sx_q[18] ? cha_pkg::Z_P180 : '0;
			end else if (sx_q == 19'sd0) begin
				z_q <= sy_q[18] ? -cha_pkg::Z_P90 : cha_pkg::Z_P90;
			end else if (ax == ay) begin
				if (sx_q[18]) z_q <= sy_q[18] ? -cha_pkg::Z_P135 : cha_pkg::Z_P135;
				else z_q <= sy_q[18] ? -cha_pkg::Z_P45 : cha_pkg::Z_P45;
			end else if (sx_q[18]) begin
				z_q <= sy_q[18] ? -cha_pkg::Z_P90 : cha_pkg::Z_P90;
			end else begin
				z_q <= '0;
			end
		end else if (cmd.cordic_step) begin
			if (!y_q[cha_pkg::V_W-1]) begin
				x_q <= x_q + ys;
				y_q <= y_q - xs;
				z_q <= z_q + tab;
			end else begin
				x_q <= x_q - ys;
				y_q <= y_q + xs;
				z_q <= z_q - tab;
			end
		end
	end

endmodule

[hw/rtl/cha_ctrl.sv]
// ----------------------------------------------------------------------------
// cha_ctrl
// Controller: sequences the two divisions and the CORDIC iterations.
// ----------------------------------------------------------------------------
module cha_ctrl #(
	parameter int unsigned ANGLE_ITERATIONS = cha_pkg::ANGLE_ITERATIONS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	input  logic              in_clear,
	output logic              in_ready,
	input  logic              out_free,
	output logic              out_load,
	input  cha_pkg::status_t  status,
	output cha_pkg::cmd_t     cmd
);

	typedef enum logic [5:0] {
		ST_IDLE     = 6'b000001,
		ST_DIV_INIT = 6'b000010,
		ST_DIV_STEP = 6'b000100,
		ST_DIV_STORE= 6'b001000,
		ST_COR_INIT = 6'b010000,
		ST_COR_STEP = 6'b100000
	} state_t;

	state_t state_q, state_d;
	logic [cha_pkg::CNT_W-1:0] cnt_q, cnt_d;
	logic axis_q, axis_d;
	logic done_q, done_d;

	always_comb begin
		state_d = state_q;
		cnt_d = cnt_q;
		axis_d = axis_q;
		done_d = done_q;
		cmd = '0;
		cmd.axis = axis_q;
		cmd.iter = cnt_q;
		in_ready = (state_q == ST_IDLE) && !done_q;
		out_load = done_q && out_free;
		if (out_load) done_d = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid && in_ready) begin
					cmd.load = 1'b1;
					cmd.clear = in_clear;
					axis_d = 1'b0;
					if (!in_clear) state_d = ST_DIV_INIT;
				end
			end
			ST_DIV_INIT: begin
				cmd.div_init = 1'b1;
				cnt_d = '0;
				state_d = ST_DIV_STEP;
			end
			ST_DIV_STEP: begin
				cmd.div_step = 1'b1;
				cnt_d = cnt_q + 1'b1;
				if (cnt_q == cha_pkg::CNT_W'(cha_pkg::DIV_STEPS - 1)) state_d = ST_DIV_STORE;
			end
			ST_DIV_STORE: begin
				cmd.div_store = 1'b1;
				if (!axis_q) begin
					axis_d = 1'b1;
					state_d = ST_DIV_INIT;
				end else begin
					state_d = ST_COR_INIT;
				end
			end
			ST_COR_INIT: begin
				cmd.cordic_init = 1'b1;
				cnt_d = '0;
				if (status.exact) begin
					done_d = 1'b1;
					state_d = ST_IDLE;
				end else begin
					state_d = ST_COR_STEP;
				end
			end
			ST_COR_STEP: begin
				cmd.cordic_step = 1'b1;
				cnt_d = cnt_q + 1'b1;
				if (cnt_q == cha_pkg::CNT_W'(ANGLE_ITERATIONS - 1)) begin
					done_d = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q <= '0;
			axis_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			state_q <= state_d;
			cnt_q <= cnt_d;
			axis_q <= axis_d;
			done_q <= done_d;
		end
	end

endmodule
